// ===== hw/rtl/xmcr_pkg.sv =====
// xmcr_pkg: shared types and constants of the x86 mode and control unit
// command and status codes, architectural bit positions, parameter defaults
// no dependencies
package xmcr_pkg;

   localparam int INT_VECTORS_DEFAULT = 32;
   localparam int CTRL_REGS_DEFAULT   = 16;

   localparam int DATA_W   = 64;
   localparam int VEC_W    = 5;
   localparam int SEL_W    = 16;
   localparam int GDT_W    = 14;
   localparam int SLOT_CNT = 6;

   localparam int BIT_PE  = 0;
   localparam int BIT_ET  = 4;
   localparam int BIT_PAE = 5;
   localparam int BIT_PG  = 31;
   localparam int BIT_LME = 8;
   localparam int BIT_LMA = 10;
   localparam int DESC_P  = 47;
   localparam int DESC_L  = 53;

   localparam logic [31:0]       EFER_ADDR = 32'hC000_0080;
   localparam logic [DATA_W-1:0] CR0_RESET = 64'h11;
   localparam int                GP_VEC    = 13;
   localparam logic [3:0]        SLOT_CS   = 4'd1;

   typedef enum logic [2:0] {
      CMD_WRCR  = 3'd0,
      CMD_RDCR  = 3'd1,
      CMD_WRMSR = 3'd2,
      CMD_RDMSR = 3'd3,
      CMD_LGDT  = 3'd4,
      CMD_LDSEL = 3'd5,
      CMD_RAISE = 3'd6,
      CMD_POLL  = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_GP    = 2'd1,
      STAT_UNSUP = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

endpackage

// ===== hw/rtl/xmcr_ram.sv =====
// xmcr_ram: generic single write port, single read port synchronous ram
// read data registered, held while no read is issued
// no dependencies
module xmcr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/xmcr_pend_enc.sv =====
// xmcr_pend_enc: lowest-numbered pending interrupt search
// priority encoder over the pending flags
// no dependencies
module xmcr_pend_enc #(
   parameter int COUNT = 32,
   localparam int AW = (COUNT > 1) ? $clog2(COUNT) : 1
) (
   input  logic [COUNT-1:0] flags,
   output logic             found,
   output logic [AW-1:0]    index
);

   always_comb begin
      found = 1'b0;
      index = '0;
      for (int i = COUNT - 1; i >= 0; i--) begin
         if (flags[i]) begin
            found = 1'b1;
            index = AW'(i);
         end
      end
   end

endmodule

// ===== hw/rtl/x86_mode_control_registers.sv =====
// x86_mode_control_registers: guest x86 mode and control register unit
// depends on xmcr_pkg, xmcr_ram, xmcr_pend_enc
//
// usage:
// one command enters on the req_ channel (valid/ready), one result leaves on
// the rsp_ channel (valid/ready) for every command.
// in the transfer cycle the unit issues the reads of the control register
// ram and of the interrupt code ram (at the lowest pending vector); in the
// exec state it checks, writes back and loads the result register.
// a new command is taken once the last one has loaded its result; the result
// register lets the next transfer happen while a result still waits on rsp_.
// if the receiver stalls, the unit finishes the following command up to the
// point of loading its result and holds there until the result register
// frees; req_ready stays low meanwhile.
// synchronous reset puts cr0 at 0x11, the other architectural flops at zero, no
// interrupt pending and no result valid; no clearing pass is needed, the first
// command may enter right after reset.
module x86_mode_control_registers #(
   parameter int INT_VECTORS = xmcr_pkg::INT_VECTORS_DEFAULT,
   parameter int CTRL_REGS   = xmcr_pkg::CTRL_REGS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_command,
   input  logic [3:0]  req_reg_index,
   input  logic [31:0] req_msr_address,
   input  logic [63:0] req_value,
   input  logic [15:0] req_gdt_limit,
   input  logic [63:0] req_descriptor,
   input  logic [4:0]  req_vector,
   input  logic        req_clear_pending,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_read_data,
   output logic [1:0]  rsp_status,
   output logic        rsp_int_found,
   output logic [4:0]  rsp_int_vector,
   output logic [63:0] rsp_int_code,
   output logic        rsp_long_mode
);

   localparam int DW        = xmcr_pkg::DATA_W;
   localparam int FLAG_CNT  = (INT_VECTORS < 32) ? INT_VECTORS : 32;
   localparam int FLAG_AW   = (FLAG_CNT > 1) ? $clog2(FLAG_CNT) : 1;
   localparam int CR_AW     = $clog2(CTRL_REGS);
   localparam bit GP_OK     = (xmcr_pkg::GP_VEC < FLAG_CNT);

   // state and handshake
   xmcr_pkg::state_type state_ff, state_in;
   logic accept;
   logic exec_go;

   // latched command
   xmcr_pkg::cmd_type cmd_ff;
   logic [3:0]        idx_ff;
   logic [31:0]       addr_ff;
   logic [DW-1:0]     val_ff;
   logic [15:0]       limit_ff;
   logic [DW-1:0]     desc_ff;
   logic [4:0]        vec_ff;
   logic              clr_ff;
   logic              poll_found_ff;
   logic [FLAG_AW-1:0] poll_idx_ff;

   // architectural state in flops
   logic [DW-1:0]                     cr0_ff, cr0_in;
   logic [DW-1:0]                     cr4_ff, cr4_in;
   logic [DW-1:0]                     efer_ff, efer_in;
   logic                              mode64_ff, mode64_in;
   logic [xmcr_pkg::GDT_W-1:0]        gdt_ff, gdt_in;
   logic [xmcr_pkg::SEL_W-1:0]        sel_ff [xmcr_pkg::SLOT_CNT];
   logic                              sel_we;
   logic [CTRL_REGS-1:0]              cr_valid_ff, cr_valid_in;
   logic [FLAG_CNT-1:0]               flags_ff, flags_in;

   // ram ports
   logic               cr_we;
   logic [DW-1:0]      cr_q;
   logic               code_we;
   logic [FLAG_AW-1:0] code_waddr;
   logic [DW-1:0]      code_wdata;
   logic [DW-1:0]      code_q;
   logic               enc_found;
   logic [FLAG_AW-1:0] enc_idx;

   // result
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]          rd_ff, rd_in;
   xmcr_pkg::status_type   st_ff, st_in;
   logic                   found_ff, found_in;
   logic [4:0]             fvec_ff, fvec_in;
   logic [DW-1:0]          fcode_ff, fcode_in;

   // exec helpers
   logic          idx_ok;
   logic [DW-1:0] cur;
   logic [DW-1:0] on_bits;
   logic [DW-1:0] off_bits;
   logic          raise_gp;
   logic          sel_index_big;

   assign req_ready = (state_ff == xmcr_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign exec_go   = (state_ff == xmcr_pkg::ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   xmcr_pend_enc #(
      .COUNT (FLAG_CNT)
   ) u_pend_enc (
      .flags (flags_ff),
      .found (enc_found),
      .index (enc_idx)
   );

   xmcr_ram #(
      .WIDTH (DW),
      .DEPTH (CTRL_REGS)
   ) u_cr_ram (
      .clock   (clock),
      .wr_en   (cr_we),
      .wr_addr (idx_ff[CR_AW-1:0]),
      .wr_data (val_ff),
      .rd_en   (accept),
      .rd_addr (req_reg_index[CR_AW-1:0]),
      .rd_data (cr_q)
   );

   xmcr_ram #(
      .WIDTH (DW),
      .DEPTH (FLAG_CNT)
   ) u_code_ram (
      .clock   (clock),
      .wr_en   (code_we),
      .wr_addr (code_waddr),
      .wr_data (code_wdata),
      .rd_en   (accept),
      .rd_addr (enc_idx),
      .rd_data (code_q)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         xmcr_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = xmcr_pkg::ST_EXEC;
            end
         end
         xmcr_pkg::ST_EXEC: begin
            if (exec_go) begin
               state_in = xmcr_pkg::ST_IDLE;
            end
         end
         default: state_in = xmcr_pkg::ST_IDLE;
      endcase
   end

   // command execution
   always_comb begin
      cr0_in       = cr0_ff;
      cr4_in       = cr4_ff;
      efer_in      = efer_ff;
      mode64_in    = mode64_ff;
      gdt_in       = gdt_ff;
      cr_valid_in  = cr_valid_ff;
      flags_in     = flags_ff;
      sel_we       = 1'b0;
      cr_we        = 1'b0;
      code_we      = 1'b0;
      code_waddr   = vec_ff[FLAG_AW-1:0];
      code_wdata   = val_ff;
      rd_in        = '0;
      st_in        = xmcr_pkg::STAT_OK;
      found_in     = 1'b0;
      fvec_in      = '0;
      fcode_in     = '0;
      raise_gp     = 1'b0;

      idx_ok = ({1'b0, idx_ff} < 5'(CTRL_REGS));
      if (idx_ff == 4'd0) begin
         cur = cr0_ff;
      end else if (idx_ff == 4'd4) begin
         cur = cr4_ff;
      end else if (idx_ok && cr_valid_ff[idx_ff[CR_AW-1:0]]) begin
         cur = cr_q;
      end else begin
         cur = '0;
      end
      on_bits  = val_ff & ~((cmd_ff == xmcr_pkg::CMD_WRMSR) ? efer_ff : cur);
      off_bits = ((cmd_ff == xmcr_pkg::CMD_WRMSR) ? efer_ff : cur) & ~val_ff;
      sel_index_big = (val_ff[DW-1:17] != '0) || (val_ff[16:3] >= gdt_ff);

      unique case (cmd_ff)
         xmcr_pkg::CMD_WRCR: begin
            if (!idx_ok) begin
               st_in = xmcr_pkg::STAT_UNSUP;
            end else if (idx_ff == 4'd0) begin
               if (off_bits[xmcr_pkg::BIT_PE]) begin
                  st_in = xmcr_pkg::STAT_UNSUP;
               end else if (on_bits[xmcr_pkg::BIT_PG] && efer_ff[xmcr_pkg::BIT_LME] &&
                            !cr4_ff[xmcr_pkg::BIT_PAE]) begin
                  raise_gp = 1'b1;
               end else begin
                  if (on_bits[xmcr_pkg::BIT_PG] && efer_ff[xmcr_pkg::BIT_LME]) begin
                     efer_in[xmcr_pkg::BIT_LMA] = 1'b1;
                  end
                  cr0_in = val_ff;
                  cr0_in[xmcr_pkg::BIT_ET] = 1'b1;
               end
            end else if (idx_ff == 4'd4) begin
               if (off_bits[xmcr_pkg::BIT_PAE] && efer_ff[xmcr_pkg::BIT_LMA]) begin
                  raise_gp = 1'b1;
               end else begin
                  cr4_in = val_ff;
               end
            end else begin
               cr_we = 1'b1;
               cr_valid_in[idx_ff[CR_AW-1:0]] = 1'b1;
            end
         end
         xmcr_pkg::CMD_RDCR: begin
            if (idx_ok) begin
               rd_in = cur;
            end else begin
               st_in = xmcr_pkg::STAT_UNSUP;
            end
         end
         xmcr_pkg::CMD_WRMSR: begin
            if (addr_ff == xmcr_pkg::EFER_ADDR) begin
               if (on_bits[xmcr_pkg::BIT_LMA]) begin
                  raise_gp = 1'b1;
               end else if ((on_bits[xmcr_pkg::BIT_LME] || off_bits[xmcr_pkg::BIT_LME]) &&
                            cr0_ff[xmcr_pkg::BIT_PG]) begin
                  raise_gp = 1'b1;
               end else begin
                  efer_in = val_ff;
               end
            end
         end
         xmcr_pkg::CMD_RDMSR: begin
            rd_in = (addr_ff == xmcr_pkg::EFER_ADDR) ? efer_ff : '1;
         end
         xmcr_pkg::CMD_LGDT: begin
            if (limit_ff[2:0] != 3'b111) begin
               raise_gp = 1'b1;
            end else begin
               gdt_in = {1'b0, limit_ff[15:3]} + 14'd1;
            end
         end
         xmcr_pkg::CMD_LDSEL: begin
            if (idx_ff >= 4'(xmcr_pkg::SLOT_CNT)) begin
               st_in = xmcr_pkg::STAT_UNSUP;
            end else if (sel_index_big || !desc_ff[xmcr_pkg::DESC_P]) begin
               raise_gp = 1'b1;
            end else if (idx_ff == xmcr_pkg::SLOT_CS && !desc_ff[xmcr_pkg::DESC_L] &&
                         mode64_ff) begin
               st_in = xmcr_pkg::STAT_UNSUP;
            end else begin
               if (idx_ff == xmcr_pkg::SLOT_CS && cr0_ff[xmcr_pkg::BIT_PE] &&
                   cr0_ff[xmcr_pkg::BIT_PG] && efer_ff[xmcr_pkg::BIT_LMA]) begin
                  mode64_in = 1'b1;
               end
               sel_we = 1'b1;
            end
         end
         xmcr_pkg::CMD_RAISE: begin
            if ({4'b0, vec_ff} < 9'(INT_VECTORS)) begin
               flags_in[vec_ff[FLAG_AW-1:0]] = 1'b1;
               code_we = 1'b1;
            end else begin
               st_in = xmcr_pkg::STAT_UNSUP;
            end
         end
         xmcr_pkg::CMD_POLL: begin
            if (poll_found_ff) begin
               found_in = 1'b1;
               fvec_in  = 5'(poll_idx_ff);
               fcode_in = code_q;
               if (clr_ff) begin
                  flags_in[poll_idx_ff] = 1'b0;
               end
            end
         end
         default: st_in = xmcr_pkg::STAT_UNSUP;
      endcase

      if (raise_gp) begin
         st_in = xmcr_pkg::STAT_GP;
         if (GP_OK) begin
            flags_in[FLAG_AW'(xmcr_pkg::GP_VEC)] = 1'b1;
            code_we    = 1'b1;
            code_waddr = FLAG_AW'(xmcr_pkg::GP_VEC);
            code_wdata = '0;
         end
      end

      if (!exec_go) begin
         cr_we   = 1'b0;
         code_we = 1'b0;
         sel_we  = 1'b0;
      end
   end

   assign rsp_valid_in = exec_go ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= xmcr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cr0_ff       <= xmcr_pkg::CR0_RESET;
         cr4_ff       <= '0;
         efer_ff      <= '0;
         mode64_ff    <= 1'b0;
         gdt_ff       <= '0;
         cr_valid_ff  <= '0;
         flags_ff     <= '0;
         for (int s = 0; s < xmcr_pkg::SLOT_CNT; s++) begin
            sel_ff[s] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (exec_go) begin
            cr0_ff      <= cr0_in;
            cr4_ff      <= cr4_in;
            efer_ff     <= efer_in;
            mode64_ff   <= mode64_in;
            gdt_ff      <= gdt_in;
            cr_valid_ff <= cr_valid_in;
            flags_ff    <= flags_in;
         end
         if (sel_we) begin
            sel_ff[idx_ff[2:0]] <= val_ff[xmcr_pkg::SEL_W-1:0];
         end
      end
   end

   // request and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff        <= xmcr_pkg::cmd_type'(req_command);
         idx_ff        <= req_reg_index;
         addr_ff       <= req_msr_address;
         val_ff        <= req_value;
         limit_ff      <= req_gdt_limit;
         desc_ff       <= req_descriptor;
         vec_ff        <= req_vector;
         clr_ff        <= req_clear_pending;
         poll_found_ff <= enc_found;
         poll_idx_ff   <= enc_idx;
      end
      if (exec_go) begin
         rd_ff    <= rd_in;
         st_ff    <= st_in;
         found_ff <= found_in;
         fvec_ff  <= fvec_in;
         fcode_ff <= fcode_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rd_ff;
   assign rsp_status     = st_ff;
   assign rsp_int_found  = found_ff;
   assign rsp_int_vector = fvec_ff;
   assign rsp_int_code   = fcode_ff;
   assign rsp_long_mode  = mode64_ff;

endmodule
